>>> src/fcnm_pkg.sv
// Package for the face center neighbor match block: constants, register
// codes, controller states and the command bundle to the datapath.
// No dependencies.
`default_nettype none

package fcnm_pkg;

	localparam int DEF_MAX_ELEMENTS = 1024;
	localparam int DEF_COORD_BITS   = 24;

	localparam int FACES      = 4;
	localparam int FACE_W     = 2;
	localparam int AXES       = 3;
	localparam int TOL_W      = 52;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = TOL_W;

	// Squared 0.001 in Q3.20 squared units.
	localparam logic [TOL_W-1:0] TOL_RESET = 52'd1099512;

	// Drain length that lets the last scan read reach the final best-match update.
	localparam int PIPE_DEPTH = 4;
	localparam int DRAIN_W    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ELEMENT_COUNT = 1'b0,
		REG_TOLERANCE     = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QLOAD,
		ST_QWAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} fsm_state_t;

	typedef struct packed {
		logic              wr_item;
		logic              capture;
		logic              clear_en;
		logic              qload_en;
		logic              scan_en;
		logic              out_en;
		logic [FACE_W-1:0] face;
	} dp_cmd_t;

endpackage

`default_nettype wire

>>> src/fcnm_ctrl.sv
// Controller for the face center neighbor match block: sequences the flag
// clearing pass, the query face load, the candidate scan and the drain.
// Depends on fcnm_pkg.
`default_nettype none

module fcnm_ctrl #(
	parameter int MAX_ELEMENTS = fcnm_pkg::DEF_MAX_ELEMENTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                mode,
	input  logic [$clog2(MAX_ELEMENTS+1)-1:0]   limit,
	output logic                                busy,
	output fcnm_pkg::dp_cmd_t                   cmd,
	output logic [$clog2(MAX_ELEMENTS)-1:0]     cmd_elem
);

	import fcnm_pkg::*;

	localparam int ELEM_W = $clog2(MAX_ELEMENTS);
	localparam int NB_W   = $clog2(MAX_ELEMENTS + 1);
	localparam logic [FACE_W-1:0] FACE_LAST = FACE_W'(FACES - 1);

	fsm_state_t          state_q;
	fsm_state_t          state_d;
	logic [ELEM_W-1:0]   elem_cnt_q;
	logic [FACE_W-1:0]   face_cnt_q;
	logic [DRAIN_W-1:0]  drain_cnt_q;
	logic                scan_last;

	assign scan_last = (face_cnt_q == FACE_LAST) &&
		(NB_W'(elem_cnt_q) == limit - NB_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (elem_cnt_q == ELEM_W'(MAX_ELEMENTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start && mode == MODE_QUERY) state_d = ST_QLOAD;
			end
			ST_QLOAD: begin
				if (face_cnt_q == FACE_LAST) state_d = ST_QWAIT;
			end
			ST_QWAIT: begin
				state_d = (limit == '0) ? ST_DRAIN : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_cnt_q == DRAIN_W'(PIPE_DEPTH - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q  <= '0;
			face_cnt_q  <= '0;
			drain_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					elem_cnt_q <= elem_cnt_q + 1'b1;
				end
				ST_IDLE: begin
					face_cnt_q <= '0;
				end
				ST_QLOAD: begin
					face_cnt_q <= face_cnt_q + 1'b1;
				end
				ST_QWAIT: begin
					elem_cnt_q  <= '0;
					face_cnt_q  <= '0;
					drain_cnt_q <= '0;
				end
				ST_SCAN: begin
					face_cnt_q <= face_cnt_q + 1'b1;
					if (face_cnt_q == FACE_LAST) elem_cnt_q <= elem_cnt_q + 1'b1;
				end
				ST_DRAIN: begin
					drain_cnt_q <= drain_cnt_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		busy         = (state_q != ST_IDLE);
		cmd          = '0;
		cmd.face     = face_cnt_q;
		cmd_elem     = elem_cnt_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
			end
			ST_IDLE: begin
				cmd.wr_item = start && (mode == MODE_WRITE);
				cmd.capture = start && (mode == MODE_QUERY);
			end
			ST_QLOAD: begin
				cmd.qload_en = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			ST_DONE: begin
				cmd.out_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// At most one datapath command is active in any cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_item, cmd.capture, cmd.clear_en, cmd.qload_en,
			cmd.scan_en, cmd.out_en}))
		else $error("fcnm_ctrl: more than one datapath command");

	// The scan never reads an element at or beyond the search limit.
	a_scan_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_en |-> (NB_W'(elem_cnt_q) < limit))
		else $error("fcnm_ctrl: scan beyond element limit");

	// A captured query always keeps the block busy in the next cycle.
	a_capture_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> busy)
		else $error("fcnm_ctrl: query capture without busy");

endmodule

`default_nettype wire

>>> src/fcnm_datapath.sv
// Datapath for the face center neighbor match block: configuration
// registers, face and flag memories, four distance lanes and best-match
// trackers, and the result registers. Depends on fcnm_pkg.
`default_nettype none

module fcnm_datapath #(
	parameter int MAX_ELEMENTS = fcnm_pkg::DEF_MAX_ELEMENTS,
	parameter int COORD_BITS   = fcnm_pkg::DEF_COORD_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  fcnm_pkg::dp_cmd_t                       cmd,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]         cmd_elem,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]       limit,
	input  logic                                    cfg_write,
	input  logic [fcnm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [fcnm_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]         element_index,
	input  logic [fcnm_pkg::FACE_W-1:0]             face_index,
	input  logic signed [COORD_BITS-1:0]            pos_x,
	input  logic signed [COORD_BITS-1:0]            pos_y,
	input  logic signed [COORD_BITS-1:0]            pos_z,
	input  logic                                    allocated,
	output logic                                    done,
	output logic [$clog2(MAX_ELEMENTS)-1:0]         queried_element,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]       neighbor_0,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]       neighbor_1,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]       neighbor_2,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]       neighbor_3
);

	import fcnm_pkg::*;

	localparam int ELEM_W = $clog2(MAX_ELEMENTS);
	localparam int NB_W   = $clog2(MAX_ELEMENTS + 1);
	localparam int ADDR_W = ELEM_W + FACE_W;
	localparam int DEPTH  = FACES * MAX_ELEMENTS;
	localparam int C      = COORD_BITS;
	localparam int SQ_W   = 2 * C;
	localparam int DIST_W = 2 * C + 2;
	localparam int CMP_W  = (DIST_W > TOL_W) ? DIST_W : TOL_W;
	localparam logic [NB_W-1:0] NONE_CODE = NB_W'(MAX_ELEMENTS);

	// Configuration registers.
	logic [NB_W-1:0]  count_q;
	logic [TOL_W-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tol_q   <= TOL_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ELEMENT_COUNT: count_q <= cfg_data[NB_W-1:0];
				REG_TOLERANCE:     tol_q   <= cfg_data[TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign limit = (count_q > NONE_CODE) ? NONE_CODE : count_q;

	// Query capture.
	logic                write_ok;
	logic [ELEM_W-1:0]   q_elem_q;
	logic                q_inrange_q;
	logic                q_flag_q;

	assign write_ok = cmd.wr_item && (NB_W'(element_index) < NONE_CODE);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			q_elem_q    <= element_index;
			q_inrange_q <= NB_W'(element_index) < NONE_CODE;
		end
	end

	// Face and flag memories.
	logic [AXES*C-1:0] face_mem [DEPTH];
	logic              flag_mem [MAX_ELEMENTS];
	logic [ADDR_W-1:0] rd_addr;
	logic [AXES*C-1:0] rdata_s1;

	assign rd_addr = cmd.qload_en ? {q_elem_q, cmd.face} : {cmd_elem, cmd.face};

	always_ff @(posedge clk) begin
		if (write_ok) face_mem[{element_index, face_index}] <= {pos_z, pos_y, pos_x};
		rdata_s1 <= face_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			flag_mem[cmd_elem] <= 1'b0;
		end else if (write_ok) begin
			flag_mem[element_index] <= allocated;
		end
		if (cmd.capture) q_flag_q <= flag_mem[element_index];
	end

	// Pipeline tags.
	logic              v_s1, v_s2, v_s3, v_s4;
	logic              ld_s1;
	logic [FACE_W-1:0] ld_face_s1;
	logic [ELEM_W-1:0] id_s1, id_s2, id_s3, id_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			ld_s1 <= 1'b0;
		end else begin
			v_s1  <= cmd.scan_en && (cmd_elem != q_elem_q);
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			ld_s1 <= cmd.qload_en;
		end
	end

	always_ff @(posedge clk) begin
		ld_face_s1 <= cmd.face;
		id_s1      <= cmd_elem;
		id_s2      <= id_s1;
		id_s3      <= id_s2;
		id_s4      <= id_s3;
	end

	// Query face centers, one lane per face.
	logic signed [C-1:0] qpos_q [FACES][AXES];
	logic signed [C-1:0] cand   [AXES];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			cand[a] = rdata_s1[a*C +: C];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			for (int a = 0; a < AXES; a++) begin
				qpos_q[ld_face_s1][a] <= cand[a];
			end
		end
	end

	// Distance lanes: magnitude, square, sum.
	logic signed [C:0]   dif    [FACES][AXES];
	logic [C-1:0]        mag    [FACES][AXES];
	logic [C-1:0]        mag_s2 [FACES][AXES];
	logic [SQ_W-1:0]     sq_s3  [FACES][AXES];
	logic [DIST_W-1:0]   sum_s4 [FACES];

	always_comb begin
		for (int f = 0; f < FACES; f++) begin
			for (int a = 0; a < AXES; a++) begin
				dif[f][a] = (C+1)'(qpos_q[f][a]) - (C+1)'(cand[a]);
				mag[f][a] = dif[f][a][C] ? C'(-dif[f][a]) : C'(dif[f][a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int f = 0; f < FACES; f++) begin
			for (int a = 0; a < AXES; a++) begin
				mag_s2[f][a] <= mag[f][a];
				sq_s3[f][a]  <= SQ_W'(mag_s2[f][a]) * SQ_W'(mag_s2[f][a]);
			end
			sum_s4[f] <= DIST_W'(sq_s3[f][0]) + DIST_W'(sq_s3[f][1]) +
				DIST_W'(sq_s3[f][2]);
		end
	end

	// Best match per query face. A strict compare keeps the earlier candidate.
	logic [FACES-1:0]  found_q;
	logic [DIST_W-1:0] best_d_q  [FACES];
	logic [ELEM_W-1:0] best_id_q [FACES];
	logic [FACES-1:0]  take;

	always_comb begin
		for (int f = 0; f < FACES; f++) begin
			take[f] = v_s4 && (CMP_W'(sum_s4[f]) < CMP_W'(tol_q)) &&
				(!found_q[f] || (sum_s4[f] < best_d_q[f]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (cmd.capture) begin
			found_q <= '0;
		end else begin
			found_q <= found_q | take;
		end
	end

	always_ff @(posedge clk) begin
		for (int f = 0; f < FACES; f++) begin
			if (take[f]) begin
				best_d_q[f]  <= sum_s4[f];
				best_id_q[f] <= id_s4;
			end
		end
	end

	// Result registers.
	logic              done_q;
	logic [ELEM_W-1:0] queried_q;
	logic [NB_W-1:0]   nb_q [FACES];
	logic              report;

	assign report = q_inrange_q && q_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.out_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_en) begin
			queried_q <= q_elem_q;
			for (int f = 0; f < FACES; f++) begin
				nb_q[f] <= (report && found_q[f]) ? NB_W'(best_id_q[f]) : NONE_CODE;
			end
		end
	end

	assign done            = done_q;
	assign queried_element = queried_q;
	assign neighbor_0      = nb_q[0];
	assign neighbor_1      = nb_q[1];
	assign neighbor_2      = nb_q[2];
	assign neighbor_3      = nb_q[3];

	// The queried element never enters the distance lanes as a candidate.
	a_no_self: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (id_s1 != q_elem_q))
		else $error("fcnm_datapath: queried element scanned as candidate");

	// Query face loads and candidate reads never share the read stage.
	a_load_scan_apart: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s1 |-> !v_s1)
		else $error("fcnm_datapath: face load overlaps candidate scan");

	// One result per query: a result beat never follows another directly.
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("fcnm_datapath: back to back result beats");

endmodule

`default_nettype wire

>>> src/face_center_neighbor_match_top.sv
// Top level of the face center neighbor match block: ports, controller and
// datapath. Depends on fcnm_pkg, fcnm_ctrl and fcnm_datapath.
`default_nettype none

// Face adjacency search over stored tetrahedron face centers. An item is
// taken at a rising edge with start high and busy low. A write beat
// (mode 0) stores one face center and the element's allocated flag, and
// busy stays low, so writes may follow each other every cycle. A query
// beat (mode 1) keeps busy high while it loads the queried element's faces,
// lets them settle, scans the faces of the first min(element_count,
// MAX_ELEMENTS) elements, one stored face per cycle from the single read
// port of the face memory while all four query faces are compared in
// parallel, then drains the distance pipeline and registers the answer.
// The result beat is shown on done for exactly one cycle, the first cycle
// in which busy is low again; the receiver cannot stall it, and a new item
// may be taken in that same cycle. After reset the block clears its
// allocated flags, one element per cycle, and holds busy high while it
// does; configuration writes are taken at any time but must only be issued
// while the block is idle. Face entries never written read as unknown, so
// every element below element_count must be written before a query.
// Neighbor value MAX_ELEMENTS means no face lay within tolerance or the
// queried element's allocated flag is clear.
module face_center_neighbor_match_top #(
	parameter int MAX_ELEMENTS = fcnm_pkg::DEF_MAX_ELEMENTS,
	parameter int COORD_BITS   = fcnm_pkg::DEF_COORD_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    mode,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]         element_index,
	input  logic [fcnm_pkg::FACE_W-1:0]             face_index,
	input  logic signed [COORD_BITS-1:0]            pos_x,
	input  logic signed [COORD_BITS-1:0]            pos_y,
	input  logic signed [COORD_BITS-1:0]            pos_z,
	input  logic                                    allocated,
	input  logic                                    cfg_write,
	input  logic [fcnm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [fcnm_pkg::CFG_DATA_W-1:0]         cfg_data,
	output logic                                    done,
	output logic [$clog2(MAX_ELEMENTS)-1:0]         queried_element,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]       neighbor_0,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]       neighbor_1,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]       neighbor_2,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]       neighbor_3
);

	import fcnm_pkg::*;

	localparam int ELEM_W = $clog2(MAX_ELEMENTS);
	localparam int NB_W   = $clog2(MAX_ELEMENTS + 1);

	// Command bundle from the controller and the scan element it points at.
	dp_cmd_t           cmd;
	logic [ELEM_W-1:0] cmd_elem;
	// Search limit, min(element_count, MAX_ELEMENTS), back to the controller.
	logic [NB_W-1:0]   limit;

	fcnm_ctrl #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.mode     (mode),
		.limit    (limit),
		.busy     (busy),
		.cmd      (cmd),
		.cmd_elem (cmd_elem)
	);

	fcnm_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.COORD_BITS   (COORD_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cmd_elem        (cmd_elem),
		.limit           (limit),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.element_index   (element_index),
		.face_index      (face_index),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.allocated       (allocated),
		.done            (done),
		.queried_element (queried_element),
		.neighbor_0      (neighbor_0),
		.neighbor_1      (neighbor_1),
		.neighbor_2      (neighbor_2),
		.neighbor_3      (neighbor_3)
	);

endmodule

`default_nettype wire
